[sv/dde_pkg.sv]
// shared constants and helpers for the decimal digit emitter
// no dependencies
`default_nettype none

package dde_pkg;

  localparam int VALUE_BITS_DEF  = 32;
  // shift-and-add-3 steps folded into one pipeline stage
  localparam int STEPS_PER_STAGE = 4;
  localparam logic [5:0] ASCII_ZERO = 6'd48;
  localparam int CHAR_W = 6;

  // number of decimal digits of the largest value of the given width, at least two
  function automatic int digit_count(input int bits);
    longint unsigned v;
    int n;
    v = (bits >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << bits) - 64'd1);
    n = 0;
    while (v != 64'd0) begin
      v = v / 10;
      n = n + 1;
    end
    return (n < 2) ? 2 : n;
  endfunction

endpackage

`default_nettype wire

[sv/dde_bcd_stage.sv]
// one pipeline stage of the binary to bcd converter (shift and add 3)
// depends on dde_pkg
`default_nettype none

module dde_bcd_stage import dde_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int NDIG       = digit_count(VALUE_BITS_DEF),
  parameter int STEPS      = STEPS_PER_STAGE
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_bin,
  input  wire logic [4*NDIG-1:0]     in_bcd,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_BITS-1:0]      out_bin,
  output logic [4*NDIG-1:0]          out_bcd
);

  logic [VALUE_BITS-1:0] bin_next;
  logic [4*NDIG-1:0]     bcd_next;

  always_comb begin
    bin_next = in_bin;
    bcd_next = in_bcd;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[4*NDIG-2:0], bin_next[VALUE_BITS-1]};
      bin_next = bin_next << 1;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_bin <= bin_next;
      out_bcd <= bcd_next;
    end
  end

endmodule

`default_nettype wire

[sv/dde_serializer.sv]
// emits the bcd digits of one number as ascii, most significant nonzero first
// depends on dde_pkg
`default_nettype none

module dde_serializer import dde_pkg::*; #(
  parameter int NDIG = digit_count(VALUE_BITS_DEF)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [4*NDIG-1:0] in_bcd,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output logic [CHAR_W-1:0]      m_char,
  output logic                   m_last
);

  localparam int POS_W = $clog2(NDIG);

  logic              busy;
  logic [4*NDIG-1:0] bcd;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  lead;
  logic              done;

  // highest nonzero digit, zero for a zero value
  always_comb begin
    lead = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (in_bcd[4*d +: 4] != 4'd0) begin
        lead = POS_W'(d);
      end
    end
  end

  assign done     = busy && m_ready && (pos == '0);
  assign in_ready = !busy || done;
  assign m_valid  = busy;
  assign m_char   = ASCII_ZERO | {2'b00, bcd[4*pos +: 4]};
  assign m_last   = (pos == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_ready) begin
      busy <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bcd <= in_bcd;
      pos <= lead;
    end else if (busy && m_ready && (pos != '0)) begin
      pos <= pos - 1'b1;
    end
  end

endmodule

`default_nettype wire

[sv/decimal_digit_emitter_top.sv]
// top level of the decimal digit emitter: bcd conversion pipeline and digit serializer
// depends on dde_pkg, dde_bcd_stage, dde_serializer
// path: the bcd conversion stages, then the load register of the serializer
// throughput: one digit per cycle on the output while m_tready is high; a number gives as
// many digits as it has (1 to 10 at 32 bits), all through the single output port of the serializer
// reset: synchronous active high rst clears all valid bits; payload registers keep their data
`default_nettype none

module decimal_digit_emitter_top import dde_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [VALUE_BITS-1:0] number, zero padded to whole bytes
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [5:0] digit_char, [7:6] zero
  output logic [7:0]                             m_tdata,
  // last digit of the number
  output logic                                   m_tlast
);

  localparam int NDIG    = digit_count(VALUE_BITS);
  localparam int NSTAGES = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // stage boundary signals, index 0 is the input side
  logic [NSTAGES:0]      vld;
  logic [NSTAGES:0]      rdy;
  logic [VALUE_BITS-1:0] bin [NSTAGES+1];
  logic [4*NDIG-1:0]     bcd [NSTAGES+1];
  logic [CHAR_W-1:0]     char_out;

  assign vld[0]   = s_tvalid;
  assign s_tready = rdy[0];
  // bits above VALUE_BITS in the padding are ignored
  assign bin[0]   = s_tdata[VALUE_BITS-1:0];
  assign bcd[0]   = '0;

  // each stage shifts in up to four bits, the last one takes what is left
  for (genvar i = 0; i < NSTAGES; i++) begin : g_stage
    localparam int LEFT  = VALUE_BITS - i * STEPS_PER_STAGE;
    localparam int STEPS = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;

    dde_bcd_stage #(
      .VALUE_BITS (VALUE_BITS),
      .NDIG       (NDIG),
      .STEPS      (STEPS)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_bin    (bin[i]),
      .in_bcd    (bcd[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_bin   (bin[i+1]),
      .out_bcd   (bcd[i+1])
    );
  end

  // serializer takes the next number in the cycle its last digit leaves
  dde_serializer #(
    .NDIG (NDIG)
  ) u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[NSTAGES]),
    .in_ready (rdy[NSTAGES]),
    .in_bcd   (bcd[NSTAGES]),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_char   (char_out),
    .m_last   (m_tlast)
  );

  assign m_tdata = {2'b00, char_out};

endmodule

`default_nettype wire

[sv/dde_checker.sv]
// port level checks for the decimal digit emitter, bound to the top level
// depends on decimal_digit_emitter_top
`default_nettype none

module dde_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // a stalled digit stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("digit request dropped while stalled");

  // a stalled digit keeps its value and last flag
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("digit request changed while stalled");

  // only ascii decimal digits leave the block
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:6] == 2'b00) && (m_tdata[5:0] >= 6'd48)
                 && (m_tdata[5:0] <= 6'd57))
    else $error("digit out of range");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind decimal_digit_emitter_top dde_checker u_dde_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

[test/decimal_digit_emitter_top_tb.sv]
// self-checking testbench for decimal_digit_emitter_top: numbers in, ascii digits out
// depends on dde_pkg and the emitter rtl; predicts every digit and checks it in order
`timescale 1ns / 100ps

module decimal_digit_emitter_top_tb import dde_pkg::*;;

  localparam int VALUE_BITS = VALUE_BITS_DEF;
  localparam int DATA_W     = ((VALUE_BITS + 7) / 8) * 8;
  // cycles with no handshake on either side before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  // extra cycles after the last digit, enough for the pipeline to flush
  localparam int FLUSH_CYCLES = 24;

  // one predicted digit, tagged with the number it came from
  typedef struct {
    logic [CHAR_W-1:0]     digit_char;
    logic                  last;
    logic [VALUE_BITS-1:0] number;
  } digit_exp_t;

  // expected digit stream, oldest first
  class digit_scoreboard_t;
    digit_exp_t pending_digits[$];

    // turn an accepted number into its digits, most significant first
    function void note_number(input logic [VALUE_BITS-1:0] n);
      logic [VALUE_BITS-1:0] v;
      digit_exp_t e;
      digit_exp_t digits[$];
      v = n;
      // the first digit peeled off is the least significant, hence the last flag
      do begin
        e.digit_char = ASCII_ZERO + CHAR_W'(v % 10);
        e.last       = (digits.size() == 0);
        e.number     = n;
        digits.push_front(e);
        v = v / 10;
      end while (v != 0);
      foreach (digits[i]) pending_digits.push_back(digits[i]);
    endfunction

    // compare one output digit with the oldest expectation
    function bit check_digit(input logic [CHAR_W-1:0] c, input logic l, output string why);
      digit_exp_t e;
      why = "";
      if (pending_digits.size() == 0) begin
        why = $sformatf("digit %0d last %0d with no request pending", c, l);
        return 1'b0;
      end
      e = pending_digits.pop_front();
      if (c !== e.digit_char)
        why = $sformatf("number %0d: digit_char %0d, predicted %0d", e.number, c, e.digit_char);
      if (l !== e.last)
        why = {why, $sformatf(" number %0d: last %0d, predicted %0d", e.number, l, e.last)};
      return (why == "");
    endfunction

    function int pending();
      return pending_digits.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;

  digit_scoreboard_t sb = new();
  int  mismatch_count = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  send_idle_on = 1'b0;
  bit  sink_stall_on = 1'b0;

  decimal_digit_emitter_top #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // mostly zero or short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // number mix: raw 32-bit values, a random digit count, decade edges, small values
  function automatic logic [VALUE_BITS-1:0] random_number();
    int unsigned sel;
    int unsigned d;
    longint unsigned p;
    longint unsigned lo;
    longint unsigned hi;
    sel = $urandom_range(9);
    p = 1;
    if (sel < 3) return $urandom();
    if (sel < 7) begin
      // uniform over the digit count, then uniform inside that decade
      d = $urandom_range(10, 1);
      repeat (d - 1) p = p * 10;
      lo = (d == 1) ? 0 : p;
      hi = p * 10 - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      return $urandom_range(hi[31:0], lo[31:0]);
    end
    if (sel == 7) begin
      // right around a power of ten, where the digit count changes
      repeat ($urandom_range(9)) p = p * 10;
      return VALUE_BITS'(p + $urandom_range(2) - 1);
    end
    return $urandom_range(20);
  endfunction

  // sender: present one number at the falling edge and hold it until taken
  task automatic send_number(input logic [VALUE_BITS-1:0] n);
    int gap;
    gap = send_idle_on ? pick_gap() : 0;
    // while idle the data lines carry junk that must be ignored
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = $urandom();
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = n;
    do @(posedge clk); while (!s_tready);
    sb.note_number(n);
  endtask

  // hold off new requests until every predicted digit has come out
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: random stalls on m_tready, one update per falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (sink_stall_on && $urandom_range(3) == 0) begin
      stall_left <= pick_gap();
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // output monitor: every digit taken is checked against the oldest prediction
  always @(posedge clk) begin
    string why;
    if (!rst && m_tvalid && m_tready) begin
      if (!sb.check_digit(m_tdata[CHAR_W-1:0], m_tlast, why)) report_mismatch(why);
    end
  end

  // hang detection: count cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d digits outstanding",
               idle_cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [VALUE_BITS-1:0] directed[$];
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero, single digits, several digit-count boundaries, full scale, bit patterns
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                 32'd99999, 32'd100000, 32'd9999999, 32'd10000000, 32'd999999999,
                 32'd1000000000, 32'd1234567890, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                 32'd0, 32'd7};
    foreach (directed[i]) send_number(directed[i]);
    wait_drained();

    // random with idling on both sides
    send_idle_on  = 1'b1;
    sink_stall_on = 1'b1;
    repeat (150) send_number(random_number());
    wait_drained();

    // back to back, no gaps anywhere
    send_idle_on  = 1'b0;
    sink_stall_on = 1'b0;
    repeat (80) send_number(random_number());

    // receiver stalls only, sender keeps the input full
    sink_stall_on = 1'b1;
    repeat (60) send_number(random_number());
    wait_drained();

    // idling again on both sides
    send_idle_on = 1'b1;
    repeat (80) send_number(random_number());

    wait_drained();
    repeat (FLUSH_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
